/* rtl/lfcr_pkg.sv */
// Shared types, constants and the CRC-16/Modbus byte update for the frame receiver.
package lfcr_pkg;

   localparam int unsigned MAX_PAYLOAD = 1024;

   localparam logic [15:0] CRC_INIT        = 16'hFFFF;
   localparam logic [15:0] CRC_POLY        = 16'hA001;
   localparam logic [10:0] HEADER_LEN      = 11'd8;
   localparam logic [10:0] LEN_CHECK_INDEX = 11'd9;
   localparam logic [16:0] TICK_MAX        = 17'h1FFFF;
   localparam logic [15:0] TIMEOUT_RESET   = 16'd2000;
   localparam logic [10:0] MAX_LEN_RESET   = 11'd512;
   localparam logic [10:0] PAYLOAD_CAP     = 11'(MAX_PAYLOAD);

   typedef enum logic [1:0] {
      KIND_BYTE = 2'd0,
      KIND_TICK = 2'd1,
      KIND_SENT = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ST_NONE         = 3'd0,
      ST_BYTE         = 3'd1,
      ST_FRAME_OK     = 3'd2,
      ST_CRC_ERROR    = 3'd3,
      ST_LENGTH_ERROR = 3'd4,
      ST_RX_TIMEOUT   = 3'd5,
      ST_NO_RESPONSE  = 3'd6
   } status_type;

   typedef enum logic {
      CSR_TIMEOUT_TICKS   = 1'b0,
      CSR_MAX_DATA_LENGTH = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] rx_byte;
   } item_type;

   typedef struct packed {
      logic [15:0] timeout_ticks;
      logic [10:0] max_data_length;
   } cfg_type;

   typedef struct packed {
      status_type  status;
      logic [7:0]  echo_byte;
      logic [10:0] byte_index;
      logic        frame_end;
      logic [7:0]  frame_address;
      logic [7:0]  frame_function;
      logic [15:0] frame_start;
      logic [15:0] frame_finish;
      logic [10:0] payload_length;
      logic        awaiting_reply;
   } result_type;

   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

/* rtl/lfcr_if.sv */
// Valid/ready channel interfaces for request items and result items.
interface lfcr_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] rx_byte;

   modport source(output valid, kind, rx_byte, input ready);
   modport sink(input valid, kind, rx_byte, output ready);
endinterface

interface lfcr_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [7:0]  echo_byte;
   logic [10:0] byte_index;
   logic        frame_end;
   logic [7:0]  frame_address;
   logic [7:0]  frame_function;
   logic [15:0] frame_start;
   logic [15:0] frame_finish;
   logic [10:0] payload_length;
   logic        awaiting_reply;

   modport source(output valid, status, echo_byte, byte_index, frame_end, frame_address,
                  frame_function, frame_start, frame_finish, payload_length,
                  awaiting_reply, input ready);
   modport sink(input valid, status, echo_byte, byte_index, frame_end, frame_address,
                frame_function, frame_start, frame_finish, payload_length,
                awaiting_reply, output ready);
endinterface

/* rtl/lfcr_frame_core.sv */
// Frame state, CRC check, length check and timeouts; one item per step.
module lfcr_frame_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  lfcr_pkg::item_type item,
   input  lfcr_pkg::cfg_type  cfg,
   output lfcr_pkg::result_type result
);
   import lfcr_pkg::*;

   logic [10:0] byte_count_ff, byte_count_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  hdr_address_ff, hdr_address_in;
   logic [7:0]  hdr_function_ff, hdr_function_in;
   logic [15:0] hdr_start_ff, hdr_start_in;
   logic [15:0] hdr_finish_ff, hdr_finish_in;
   logic [15:0] hdr_length_ff, hdr_length_in;
   logic [7:0]  crc_low_ff, crc_low_in;
   logic [16:0] idle_ticks_ff, idle_ticks_in;
   logic [16:0] since_send_ff, since_send_in;
   logic        waiting_ff, waiting_in;

   logic [10:0] limit;
   logic [16:0] idx_wide;
   logic [16:0] body_end;
   logic [16:0] timeout_wide;

   always_comb begin
      byte_count_in   = byte_count_ff;
      crc_in          = crc_ff;
      hdr_address_in  = hdr_address_ff;
      hdr_function_in = hdr_function_ff;
      hdr_start_in    = hdr_start_ff;
      hdr_finish_in   = hdr_finish_ff;
      hdr_length_in   = hdr_length_ff;
      crc_low_in      = crc_low_ff;
      idle_ticks_in   = idle_ticks_ff;
      since_send_in   = since_send_ff;
      waiting_in      = waiting_ff;
      result          = '0;
      result.status   = ST_NONE;

      limit        = (cfg.max_data_length > PAYLOAD_CAP) ? PAYLOAD_CAP : cfg.max_data_length;
      idx_wide     = {6'd0, byte_count_ff};
      body_end     = {1'b0, hdr_length_ff} + {6'd0, HEADER_LEN};
      timeout_wide = {1'b0, cfg.timeout_ticks};

      unique case (item.kind)
         KIND_BYTE: begin
            result.status     = ST_BYTE;
            result.echo_byte  = item.rx_byte;
            result.byte_index = byte_count_ff;
            unique case (byte_count_ff)
               11'd0:   hdr_address_in  = item.rx_byte;
               11'd1:   hdr_function_in = item.rx_byte;
               11'd2:   hdr_start_in    = {item.rx_byte, 8'h00};
               11'd3:   hdr_start_in    = {hdr_start_ff[15:8], item.rx_byte};
               11'd4:   hdr_finish_in   = {item.rx_byte, 8'h00};
               11'd5:   hdr_finish_in   = {hdr_finish_ff[15:8], item.rx_byte};
               11'd6:   hdr_length_in   = {item.rx_byte, 8'h00};
               11'd7:   hdr_length_in   = {hdr_length_ff[15:8], item.rx_byte};
               default: ;
            endcase
            priority if (byte_count_ff < HEADER_LEN || idx_wide < body_end) begin
               crc_in = crc16_byte(crc_ff, item.rx_byte);
            end else if (idx_wide == body_end) begin
               crc_low_in = item.rx_byte;
            end else begin
            end
            byte_count_in = byte_count_ff + 11'd1;
            idle_ticks_in = '0;
            priority if (byte_count_ff >= LEN_CHECK_INDEX &&
                         hdr_length_ff > {5'd0, limit}) begin
               result.status    = ST_LENGTH_ERROR;
               result.frame_end = 1'b1;
               byte_count_in    = '0;
               crc_in           = CRC_INIT;
            end else if (byte_count_ff >= LEN_CHECK_INDEX &&
                         idx_wide == body_end + 17'd1) begin
               result.frame_end = 1'b1;
               if ({item.rx_byte, crc_low_ff} == crc_ff) begin
                  result.status         = ST_FRAME_OK;
                  result.frame_address  = hdr_address_ff;
                  result.frame_function = hdr_function_ff;
                  result.frame_start    = hdr_start_ff;
                  result.frame_finish   = hdr_finish_ff;
                  result.payload_length = hdr_length_ff[10:0];
                  waiting_in            = 1'b0;
               end else begin
                  result.status = ST_CRC_ERROR;
               end
               byte_count_in = '0;
               crc_in        = CRC_INIT;
            end else begin
            end
         end
         KIND_TICK: begin
            if (idle_ticks_ff < TICK_MAX) begin
               idle_ticks_in = idle_ticks_ff + 17'd1;
            end
            if (since_send_ff < TICK_MAX) begin
               since_send_in = since_send_ff + 17'd1;
            end
            priority if (waiting_ff && byte_count_ff != '0 &&
                         idle_ticks_in > timeout_wide) begin
               byte_count_in    = '0;
               crc_in           = CRC_INIT;
               waiting_in       = 1'b0;
               result.status    = ST_RX_TIMEOUT;
               result.frame_end = 1'b1;
            end else if (waiting_ff && byte_count_ff == '0 &&
                         since_send_in > timeout_wide) begin
               waiting_in    = 1'b0;
               result.status = ST_NO_RESPONSE;
            end else begin
            end
         end
         KIND_SENT: begin
            since_send_in = '0;
            waiting_in    = 1'b1;
         end
         default: ;
      endcase

      result.awaiting_reply = waiting_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff   <= '0;
         crc_ff          <= CRC_INIT;
         hdr_address_ff  <= '0;
         hdr_function_ff <= '0;
         hdr_start_ff    <= '0;
         hdr_finish_ff   <= '0;
         hdr_length_ff   <= '0;
         crc_low_ff      <= '0;
         idle_ticks_ff   <= '0;
         since_send_ff   <= '0;
         waiting_ff      <= 1'b0;
      end else if (step) begin
         byte_count_ff   <= byte_count_in;
         crc_ff          <= crc_in;
         hdr_address_ff  <= hdr_address_in;
         hdr_function_ff <= hdr_function_in;
         hdr_start_ff    <= hdr_start_in;
         hdr_finish_ff   <= hdr_finish_in;
         hdr_length_ff   <= hdr_length_in;
         crc_low_ff      <= crc_low_in;
         idle_ticks_ff   <= idle_ticks_in;
         since_send_ff   <= since_send_in;
         waiting_ff      <= waiting_in;
      end
   end

   a_end_clears_frame: assert property (@(posedge clock) disable iff (reset)
      step && result.frame_end |=> byte_count_ff == '0 && crc_ff == CRC_INIT)
      else $error("frame end did not clear the frame");

   a_sent_arms_wait: assert property (@(posedge clock) disable iff (reset)
      step && item.kind == KIND_SENT |=> waiting_ff && since_send_ff == '0)
      else $error("request sent did not arm the wait");

   a_ok_ends_wait: assert property (@(posedge clock) disable iff (reset)
      step && result.status == ST_FRAME_OK |=> !waiting_ff)
      else $error("good frame left the wait armed");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      byte_count_ff <= PAYLOAD_CAP + LEN_CHECK_INDEX)
      else $error("byte count ran past the longest frame");

endmodule

/* rtl/length_framed_crc16_frame_receiver_unit.sv */
// Top level of the length-framed CRC-16/Modbus frame receiver.
//
//   channel  direction  handshake            content
//   req_ch   in         valid/ready          kind, rx_byte
//   rsp_ch   out        valid/ready          status, echo, index, header, wait flag
//   csr_*    in         write enable only    timeout_ticks, max_data_length
//
// One item per cycle while results are taken; each item's result passes through the input
// register, then the result register behind the byte-wide CRC and frame logic.
// Synchronous active-high reset empties both registers and restores the frame state.
// A stalled result holds; the input register still takes an item while the result
// waits, and acceptance stops only when both registers are full.
module length_framed_crc16_frame_receiver_unit (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_enable,
   input  logic                csr_index,
   input  logic [15:0]         csr_write_data,
   lfcr_req_if.sink            req_ch,
   lfcr_rsp_if.source          rsp_ch
);
   import lfcr_pkg::*;

   cfg_type    cfg_ff;
   logic       req_valid_ff, req_valid_in;
   item_type   req_item_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff;
   result_type result;
   logic       rsp_free;
   logic       step;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.timeout_ticks   <= TIMEOUT_RESET;
         cfg_ff.max_data_length <= MAX_LEN_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_TIMEOUT_TICKS:   cfg_ff.timeout_ticks   <= csr_write_data;
            CSR_MAX_DATA_LENGTH: cfg_ff.max_data_length <= csr_write_data[10:0];
            default: ;
         endcase
      end
   end

   assign rsp_free     = !rsp_valid_ff || rsp_ch.ready;
   assign step         = req_valid_ff && rsp_free;
   assign req_ch.ready = !req_valid_ff || step;

   always_comb begin
      req_valid_in = req_ch.ready ? req_ch.valid : req_valid_ff;
      rsp_valid_in = rsp_free ? step : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         req_item_ff <= '{kind: req_ch.kind, rx_byte: req_ch.rx_byte};
      end
      if (step) begin
         rsp_ff <= result;
      end
   end

   lfcr_frame_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (req_item_ff),
      .cfg    (cfg_ff),
      .result (result)
   );

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.status         = rsp_ff.status;
   assign rsp_ch.echo_byte      = rsp_ff.echo_byte;
   assign rsp_ch.byte_index     = rsp_ff.byte_index;
   assign rsp_ch.frame_end      = rsp_ff.frame_end;
   assign rsp_ch.frame_address  = rsp_ff.frame_address;
   assign rsp_ch.frame_function = rsp_ff.frame_function;
   assign rsp_ch.frame_start    = rsp_ff.frame_start;
   assign rsp_ch.frame_finish   = rsp_ff.frame_finish;
   assign rsp_ch.payload_length = rsp_ff.payload_length;
   assign rsp_ch.awaiting_reply = rsp_ff.awaiting_reply;

endmodule

/* tb/sv/tb_length_framed_crc16_frame_receiver_unit.sv */
// Self-checking testbench for the length-framed CRC-16/Modbus frame receiver.
module tb_length_framed_crc16_frame_receiver_unit;
   import lfcr_pkg::*;

   localparam logic [1:0]  KIND_UNUSED = 2'd3;
   localparam int unsigned CYCLE_LIMIT = 1_000_000;
   localparam int unsigned HOLDOFF_CYCLES = 400;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_enable;
   logic        csr_index;
   logic [15:0] csr_write_data;

   lfcr_req_if req_ch();
   lfcr_rsp_if rsp_ch();

   length_framed_crc16_frame_receiver_unit uut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_ch           (req_ch),
      .rsp_ch           (rsp_ch)
   );

   always #10 clock = ~clock;

   item_type    pending_items[$];
   result_type  expected_results[$];
   int unsigned send_idle_pct = 0;
   int unsigned rsp_stall_pct = 0;
   int unsigned traffic_count = 0;
   int unsigned mismatches = 0;
   int unsigned cycle_count = 0;
   int unsigned holdoff_left = 0;
   logic        holdoff_go = 1'b0;

   // receiver state as predicted
   logic [15:0] timeout_limit;
   logic [10:0] len_limit;
   logic [10:0] rx_count;
   logic [15:0] crc_acc;
   logic [7:0]  frm_addr;
   logic [7:0]  frm_func;
   logic [15:0] frm_first;
   logic [15:0] frm_last;
   logic [15:0] frm_len;
   logic [7:0]  crc_tail;
   logic [16:0] quiet_ticks;
   logic [16:0] reply_ticks;
   logic        awaiting;

   function automatic logic [15:0] modbus_crc_step(input logic [15:0] acc, input logic [7:0] data);
      logic [15:0] v;
      logic        fb;
      v = acc;
      for (int i = 0; i < 8; i++) begin
         fb = v[0] ^ data[i];
         v = {1'b0, v[15:1]};
         if (fb) v = v ^ CRC_POLY;
      end
      return v;
   endfunction

   function automatic int unsigned effective_cap();
      return (len_limit > PAYLOAD_CAP) ? int'(PAYLOAD_CAP) : int'(len_limit);
   endfunction

   function automatic result_type predict_frame_result(input item_type it);
      result_type  r;
      int unsigned pos;
      int unsigned cap;
      r = '0;
      r.status = ST_NONE;
      case (it.kind)
         KIND_BYTE: begin
            cap = effective_cap();
            pos = rx_count;
            r.status = ST_BYTE;
            r.echo_byte = it.rx_byte;
            r.byte_index = rx_count;
            case (pos)
               0: frm_addr = it.rx_byte;
               1: frm_func = it.rx_byte;
               2: frm_first = {it.rx_byte, 8'h00};
               3: frm_first[7:0] = it.rx_byte;
               4: frm_last = {it.rx_byte, 8'h00};
               5: frm_last[7:0] = it.rx_byte;
               6: frm_len = {it.rx_byte, 8'h00};
               7: frm_len[7:0] = it.rx_byte;
               default: ;
            endcase
            if (pos < 32'(HEADER_LEN) + 32'(frm_len)) crc_acc = modbus_crc_step(crc_acc, it.rx_byte);
            else if (pos == 32'(HEADER_LEN) + 32'(frm_len)) crc_tail = it.rx_byte;
            rx_count = 11'(pos + 1);
            quiet_ticks = '0;
            if (pos >= 32'(LEN_CHECK_INDEX) && 32'(frm_len) > cap) begin
               r.status = ST_LENGTH_ERROR;
               r.frame_end = 1'b1;
               rx_count = '0;
               crc_acc = CRC_INIT;
            end else if (pos >= 32'(LEN_CHECK_INDEX)
                         && pos == 32'(LEN_CHECK_INDEX) + 32'(frm_len)) begin
               r.frame_end = 1'b1;
               if ({it.rx_byte, crc_tail} == crc_acc) begin
                  r.status = ST_FRAME_OK;
                  r.frame_address = frm_addr;
                  r.frame_function = frm_func;
                  r.frame_start = frm_first;
                  r.frame_finish = frm_last;
                  r.payload_length = frm_len[10:0];
                  awaiting = 1'b0;
               end else begin
                  r.status = ST_CRC_ERROR;
               end
               rx_count = '0;
               crc_acc = CRC_INIT;
            end
         end
         KIND_TICK: begin
            if (quiet_ticks != TICK_MAX) quiet_ticks = quiet_ticks + 1'b1;
            if (reply_ticks != TICK_MAX) reply_ticks = reply_ticks + 1'b1;
            if (awaiting && rx_count != 0 && quiet_ticks > timeout_limit) begin
               rx_count = '0;
               crc_acc = CRC_INIT;
               awaiting = 1'b0;
               r.status = ST_RX_TIMEOUT;
               r.frame_end = 1'b1;
            end else if (awaiting && rx_count == 0 && reply_ticks > timeout_limit) begin
               awaiting = 1'b0;
               r.status = ST_NO_RESPONSE;
            end
         end
         KIND_SENT: begin
            reply_ticks = '0;
            awaiting = 1'b1;
         end
         default: ;
      endcase
      r.awaiting_reply = awaiting;
      return r;
   endfunction

   task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endtask

   // driver: offer pending items, hold each until taken
   always @(posedge clock) begin : drive_req
      result_type predicted;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            predicted = predict_frame_result(pending_items.pop_front());
            expected_results = {expected_results, predicted};
         end
         if (!(req_ch.valid && !req_ch.ready)) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_ch.valid <= 1'b1;
               req_ch.kind <= pending_items[0].kind;
               req_ch.rx_byte <= pending_items[0].rx_byte;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // monitor: compare each taken result with the oldest prediction
   always @(posedge clock) begin : watch_rsp
      result_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_results.size() == 0) begin
               $error("result with nothing expected: status %0d", rsp_ch.status);
               mismatches++;
            end else begin
               want = expected_results.pop_front();
               check_field("status", 16'(want.status), 16'(rsp_ch.status));
               check_field("echo_byte", 16'(want.echo_byte), 16'(rsp_ch.echo_byte));
               check_field("byte_index", 16'(want.byte_index), 16'(rsp_ch.byte_index));
               check_field("frame_end", 16'(want.frame_end), 16'(rsp_ch.frame_end));
               check_field("frame_address", 16'(want.frame_address), 16'(rsp_ch.frame_address));
               check_field("frame_function", 16'(want.frame_function),
                           16'(rsp_ch.frame_function));
               check_field("frame_start", want.frame_start, rsp_ch.frame_start);
               check_field("frame_finish", want.frame_finish, rsp_ch.frame_finish);
               check_field("payload_length", 16'(want.payload_length),
                           16'(rsp_ch.payload_length));
               check_field("awaiting_reply", 16'(want.awaiting_reply),
                           16'(rsp_ch.awaiting_reply));
            end
         end
         rsp_ch.ready <= (holdoff_left == 0) && ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin : hold_rsp
      if (reset) holdoff_left <= 0;
      else if (holdoff_go) holdoff_left <= HOLDOFF_CYCLES;
      else if (holdoff_left != 0) holdoff_left <= holdoff_left - 1;
   end

   always @(posedge clock) begin : watchdog
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("length_framed_crc16_frame_receiver_unit test failed");
         $finish;
      end
   end

   task automatic queue_item(input logic [1:0] kind, input logic [7:0] data);
      item_type it;
      it.kind = kind;
      it.rx_byte = data;
      pending_items = {pending_items, it};
      if (kind != KIND_UNUSED) traffic_count++;
   endtask

   task automatic queue_ticks(input int unsigned count);
      repeat (count) queue_item(KIND_TICK, 8'($urandom));
   endtask

   // queue one frame; a length over the limit stops after the length check byte
   task automatic queue_frame(input logic [7:0] addr, input logic [7:0] func,
                              input logic [15:0] first, input logic [15:0] last,
                              input logic [15:0] len, input bit bad_crc,
                              input int unsigned tick_pct);
      logic [63:0] head;
      logic [7:0]  frame_bytes[$];
      logic [15:0] crc;
      head = {addr, func, first, last, len};
      for (int i = 7; i >= 0; i--) frame_bytes = {frame_bytes, head[i*8 +: 8]};
      if (32'(len) > effective_cap()) begin
         repeat (2) frame_bytes = {frame_bytes, 8'($urandom)};
      end else begin
         repeat (len) frame_bytes = {frame_bytes, 8'($urandom)};
         crc = CRC_INIT;
         foreach (frame_bytes[i]) crc = modbus_crc_step(crc, frame_bytes[i]);
         if (bad_crc) crc = crc ^ (16'd1 << $urandom_range(15));
         frame_bytes = {frame_bytes, crc[7:0]};
         frame_bytes = {frame_bytes, crc[15:8]};
      end
      foreach (frame_bytes[i]) begin
         queue_item(KIND_BYTE, frame_bytes[i]);
         if ($urandom_range(99) < tick_pct) queue_item(KIND_TICK, 8'($urandom));
      end
   endtask

   task automatic queue_random_traffic(input int unsigned count);
      int unsigned base;
      int unsigned sel;
      int unsigned cap;
      int unsigned len;
      int unsigned gap;
      base = traffic_count;
      while (traffic_count - base < count) begin
         sel = $urandom_range(99);
         cap = effective_cap();
         gap = (timeout_limit < 38) ? 32'(timeout_limit) + 1 + $urandom_range(1) : 3;
         if (sel < 62) begin
            if ($urandom_range(9) != 0) queue_item(KIND_SENT, 8'($urandom));
            len = ($urandom_range(49) == 0) ? $urandom_range(cap)
                                            : $urandom_range((cap < 12) ? cap : 12);
            queue_frame(8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom), 16'(len),
                        $urandom_range(9) == 0, (timeout_limit > 1) ? 8 : 0);
         end else if (sel < 70) begin
            queue_item(KIND_SENT, 8'($urandom));
            queue_frame(8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
                        16'($urandom_range(16'hFFFF, cap + 1)), 1'b0, 0);
         end else if (sel < 80) begin
            queue_item(KIND_SENT, 8'($urandom));
            repeat ($urandom_range(1, 8)) queue_item(KIND_BYTE, 8'($urandom));
            queue_ticks(gap);
         end else if (sel < 88) begin
            queue_item(KIND_SENT, 8'($urandom));
            queue_ticks(gap);
         end else begin
            repeat ($urandom_range(1, 4)) queue_item(2'($urandom_range(3)), 8'($urandom));
         end
      end
   endtask

   task automatic wait_drained();
      while (pending_items.size() != 0 || expected_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input logic [15:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CSR_TIMEOUT_TICKS:   timeout_limit = value;
         CSR_MAX_DATA_LENGTH: len_limit = value[10:0];
         default: ;
      endcase
   endtask

   task automatic configure(input logic [15:0] tmo, input logic [10:0] max_len);
      wait_drained();
      write_register(CSR_TIMEOUT_TICKS, tmo);
      write_register(CSR_MAX_DATA_LENGTH, 16'(max_len));
   endtask

   initial begin
      req_ch.valid = 1'b0;
      req_ch.kind = '0;
      req_ch.rx_byte = '0;
      rsp_ch.ready = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = CSR_TIMEOUT_TICKS;
      csr_write_data = '0;
      timeout_limit = TIMEOUT_RESET;
      len_limit = MAX_LEN_RESET;
      rx_count = '0;
      crc_acc = CRC_INIT;
      frm_addr = '0;
      frm_func = '0;
      frm_first = '0;
      frm_last = '0;
      frm_len = '0;
      crc_tail = '0;
      quiet_ticks = '0;
      reply_ticks = '0;
      awaiting = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset settings: ignored kind, idle tick, request sent, good empty frame, length over the limit
      queue_item(KIND_UNUSED, 8'hFF);
      queue_item(KIND_TICK, 8'h00);
      queue_item(KIND_SENT, 8'hAA);
      queue_frame(8'hFF, 8'h00, 16'hFFFF, 16'h0000, 16'd0, 1'b0, 0);
      queue_frame(8'h00, 8'hFF, 16'h0000, 16'hFFFF, 16'd513, 1'b0, 0);

      configure(16'd1, 11'd0);
      send_idle_pct = 56;
      queue_frame(8'h5A, 8'h03, 16'h1234, 16'h00FF, 16'd0, 1'b1, 0);
      queue_item(KIND_SENT, 8'h55);
      queue_item(KIND_BYTE, 8'h01);
      queue_item(KIND_BYTE, 8'h04);
      queue_ticks(3);
      queue_item(KIND_SENT, 8'h00);
      queue_ticks(3);
      queue_random_traffic(150);

      configure(16'd0, 11'd1024);
      send_idle_pct = 0;
      rsp_stall_pct = 56;
      queue_random_traffic(150);
      @(posedge clock);
      holdoff_go <= 1'b1;
      @(posedge clock);
      holdoff_go <= 1'b0;

      configure(16'd5, 11'h7FF);
      send_idle_pct = 25;
      rsp_stall_pct = 25;
      queue_item(KIND_SENT, 8'h0F);
      queue_frame(8'h11, 8'h04, 16'h0001, 16'h0200, 16'd1024, 1'b0, 0);
      queue_frame(8'h11, 8'h04, 16'h0001, 16'h0200, 16'd1025, 1'b0, 0);
      queue_random_traffic(100);

      configure(16'hFFFF, 11'd300);
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      queue_random_traffic(100);

      configure(16'd3, 11'd17);
      send_idle_pct = 25;
      rsp_stall_pct = 25;
      queue_random_traffic(150);

      // drop any wait, leave a partial frame, then tick while it stays stale
      configure(16'd0, 11'd17);
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      queue_ticks(2);
      configure(16'hFFFF, 11'd17);
      do begin
         queue_item(KIND_BYTE, 8'($urandom));
         wait_drained();
      end while (rx_count == 0);
      queue_ticks(40);
      queue_item(KIND_SENT, 8'h3C);
      queue_item(KIND_TICK, 8'hC3);

      wait_drained();
      repeat (8) @(posedge clock);
      if (mismatches == 0)
         $display("length_framed_crc16_frame_receiver_unit test passed");
      else
         $display("length_framed_crc16_frame_receiver_unit test failed");
      $finish;
   end

endmodule

/* length_framed_crc16_frame_receiver_unit.f */
rtl/lfcr_pkg.sv
rtl/lfcr_if.sv
rtl/lfcr_frame_core.sv
rtl/length_framed_crc16_frame_receiver_unit.sv
tb/sv/tb_length_framed_crc16_frame_receiver_unit.sv
